### design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/msdit_pkg.sv
// Package for the multi-slot delay and interval timer.
// Holds opcodes, event kinds, sequencer states, item structs and default sizes; no dependencies.
package msdit_pkg;

    // Default table size and time width (unsigned Q16.16 at the default width).
    localparam int SLOT_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // At most this many fire events are reported for one tick.
    localparam int MAX_OUT = 16;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DESTROY = 3'd2,
        OP_CANCEL  = 3'd3,
        OP_PAUSE   = 3'd4,
        OP_RESUME  = 3'd5,
        OP_COUNT   = 3'd6,
        OP_QUERY   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        EV_ACK     = 2'd0,
        EV_FIRED   = 2'd1,
        EV_NO_SLOT = 2'd2,
        EV_FULL    = 2'd3
    } t_evt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_TICK,
        ST_FREE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op         opcode;
        logic [3:0]  slot;
        logic [31:0] first_delay;
        logic [31:0] repeat_interval;
        logic        use_scaled;
        logic [31:0] tick_scaled;
        logic [31:0] tick_unscaled;
    } t_cmd;

    typedef struct packed {
        t_evt       event_kind;
        logic [3:0] result_slot;
        logic [4:0] running_count;
        logic       slot_exists;
        logic       last_result;
    } t_res;

endpackage

### design/multi_slot_delay_interval_timer.sv
// Multi-slot delay and interval timer, top level.
// Depends on msdit_pkg and on assert_macros.svh for its checks.
//
// Usage:
//   An item (t_cmd on i_cmd) is taken at a rising edge with start high and busy low.
//   busy stays high until the last result of that item has been shown. Results
//   (t_res on o_res) are shown one at a time, each for exactly one cycle while
//   o_res_strobe is high; last_result marks the final one. The receiver cannot
//   stall: every strobed result counts as taken.
//   Steps of an item:
//     tick:        a sweep of the slots and a free step, then one quiet acknowledge, or
//                  a scan of the fired slots that ends at the last reported one.
//     other items: a table scan, an update step, a result step.
//   The slot sweep is a three-step pipeline (memory read, saturating add,
//   compare and subtract) over one shared adder and subtractor, one slot per
//   cycle; the scans step through the slot flags one slot per cycle.
//   Reset (synchronous, i_rst_n low) frees every slot and returns to idle; the
//   delay, interval and elapsed memories need no clearing since only slots in
//   use, always written by create, are ever read.
module multi_slot_delay_interval_timer #(
    parameter int SLOT_COUNT = msdit_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = msdit_pkg::TIME_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  msdit_pkg::t_cmd i_cmd,
    output logic            o_res_strobe,
    output msdit_pkg::t_res o_res
);
    import msdit_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 2);
    localparam int SEXT_W = IDX_W + 4;

    typedef logic [TIME_BITS-1:0] t_time;

    // Control registers.
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    logic [SLOT_COUNT-1:0] r_running, n_running;
    logic [SLOT_COUNT-1:0] r_cancel, n_cancel;
    logic [SLOT_COUNT-1:0] r_has_fired, n_has_fired;
    logic [SLOT_COUNT-1:0] r_scaled, n_scaled;
    logic [SLOT_COUNT-1:0] r_fired, n_fired;
    logic                  r_a_vld, n_a_vld;
    logic                  r_b_vld, n_b_vld;

    // Payload registers.
    t_cmd                  r_cmd, n_cmd;
    logic [4:0]            r_cnt, n_cnt;
    logic [4:0]            r_fire_n, n_fire_n;
    logic [4:0]            r_emit_n, n_emit_n;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_single, n_single;
    t_evt                  r_kind, n_kind;
    logic [3:0]            r_rslot, n_rslot;
    logic                  r_exists, n_exists;
    logic [IDX_W-1:0]      r_a_idx, n_a_idx;
    logic [IDX_W-1:0]      r_b_idx, n_b_idx;
    logic                  r_b_act, n_b_act;
    logic                  r_b_per, n_b_per;
    t_time                 r_b_sum, n_b_sum;
    t_time                 r_b_thr, n_b_thr;

    // Per-slot time memories and their registered read data.
    t_time                 mem_elapsed  [SLOT_COUNT];
    t_time                 mem_delay    [SLOT_COUNT];
    t_time                 mem_interval [SLOT_COUNT];
    t_time                 r_el_q, r_dl_q, r_iv_q;

    logic                  el_we, cfg_we;
    logic [IDX_W-1:0]      el_waddr, cfg_waddr, rd_addr;
    t_time                 el_wdata;

    // Shared arithmetic and decoded fields.
    logic [SEXT_W-1:0]     slot_ext;
    logic [IDX_W-1:0]      s_idx;
    logic                  s_ok;
    logic [IDX_W-1:0]      scan_idx;
    logic                  a_act;
    t_time                 a_dt, a_sum, a_thr;
    logic [TIME_BITS:0]    a_sum_w;
    logic [TIME_BITS:0]    b_diff_w;
    logic                  b_ge;
    logic                  s_counted;

    assign busy     = (r_state != ST_IDLE);
    assign scan_idx = r_idx[IDX_W-1:0];
    assign rd_addr  = scan_idx;

    // Addressed slot: out-of-range indexes read as not in use.
    assign slot_ext  = SEXT_W'(r_cmd.slot);
    assign s_idx     = slot_ext[IDX_W-1:0];
    assign s_ok      = (slot_ext < SEXT_W'(SLOT_COUNT)) && r_in_use[s_idx];
    assign s_counted = r_running[s_idx] && !r_cancel[s_idx];

    // Sweep step two: pick the step, saturating add and threshold choice.
    always_comb begin
        a_act   = r_in_use[r_a_idx] && r_running[r_a_idx] && !r_cancel[r_a_idx];
        a_dt    = r_scaled[r_a_idx] ? TIME_BITS'(r_cmd.tick_scaled)
                                    : TIME_BITS'(r_cmd.tick_unscaled);
        a_sum_w = {1'b0, r_el_q} + {1'b0, a_dt};
        a_sum   = a_sum_w[TIME_BITS] ? '1 : a_sum_w[TIME_BITS-1:0];
        a_thr   = r_has_fired[r_a_idx] ? r_iv_q : r_dl_q;
    end

    // Sweep step three: compare by subtraction, the difference is the kept excess.
    assign b_diff_w = {1'b0, r_b_sum} - {1'b0, r_b_thr};
    assign b_ge     = !b_diff_w[TIME_BITS];

    // Sequencer: next state, flag updates and result outputs.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_in_use    = r_in_use;
        n_running   = r_running;
        n_cancel    = r_cancel;
        n_has_fired = r_has_fired;
        n_scaled    = r_scaled;
        n_fired     = r_fired;
        n_a_vld     = 1'b0;
        n_b_vld     = r_a_vld;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_fire_n    = r_fire_n;
        n_emit_n    = r_emit_n;
        n_found     = r_found;
        n_free_idx  = r_free_idx;
        n_single    = r_single;
        n_kind      = r_kind;
        n_rslot     = r_rslot;
        n_exists    = r_exists;
        n_a_idx     = scan_idx;
        n_b_idx     = r_a_idx;
        n_b_act     = a_act;
        n_b_per     = (r_iv_q != '0);
        n_b_sum     = a_sum;
        n_b_thr     = a_thr;
        el_we       = 1'b0;
        el_waddr    = r_b_idx;
        el_wdata    = r_b_sum;
        cfg_we      = 1'b0;
        cfg_waddr   = r_free_idx;
        o_res_strobe = 1'b0;
        o_res        = '{event_kind: r_kind, result_slot: r_rslot, running_count: r_cnt,
                         slot_exists: r_exists, last_result: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_fire_n = '0;
                    n_found  = 1'b0;
                    n_fired  = '0;
                    n_exists = 1'b0;
                    n_single = 1'b1;
                    n_state  = (i_cmd.opcode == OP_TICK) ? ST_TICK : ST_SCAN;
                end
            end

            // Count running slots and find the lowest free one.
            ST_SCAN: begin
                if (r_in_use[scan_idx] && r_running[scan_idx] && !r_cancel[scan_idx]) begin
                    n_cnt = r_cnt + 5'd1;
                end
                if (!r_found && !r_in_use[scan_idx]) begin
                    n_found    = 1'b1;
                    n_free_idx = scan_idx;
                end
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(SLOT_COUNT - 1)) begin
                    n_state = ST_APPLY;
                end
            end

            // Carry out a table command and adjust the running count.
            ST_APPLY: begin
                n_kind  = EV_ACK;
                n_rslot = r_cmd.slot;
                n_state = ST_EMIT;
                unique case (r_cmd.opcode) inside
                    OP_CREATE: begin
                        if (r_found) begin
                            n_in_use[r_free_idx]    = 1'b1;
                            n_running[r_free_idx]   = 1'b1;
                            n_cancel[r_free_idx]    = 1'b0;
                            n_has_fired[r_free_idx] = 1'b0;
                            n_scaled[r_free_idx]    = r_cmd.use_scaled;
                            cfg_we   = 1'b1;
                            el_we    = 1'b1;
                            el_waddr = r_free_idx;
                            el_wdata = '0;
                            n_cnt    = r_cnt + 5'd1;
                            n_rslot  = 4'(r_free_idx);
                        end else begin
                            n_kind  = EV_FULL;
                            n_rslot = 4'd0;
                        end
                    end
                    OP_DESTROY, OP_CANCEL, OP_PAUSE, OP_RESUME: begin
                        if (!s_ok) begin
                            n_kind = EV_NO_SLOT;
                        end else if (r_cmd.opcode == OP_DESTROY) begin
                            n_in_use[s_idx]    = 1'b0;
                            n_running[s_idx]   = 1'b0;
                            n_cancel[s_idx]    = 1'b0;
                            n_has_fired[s_idx] = 1'b0;
                            n_scaled[s_idx]    = 1'b0;
                            n_cnt = r_cnt - 5'(s_counted);
                        end else if (r_cmd.opcode == OP_CANCEL) begin
                            n_cancel[s_idx]  = 1'b1;
                            n_running[s_idx] = 1'b0;
                            n_cnt = r_cnt - 5'(s_counted);
                        end else if (r_cmd.opcode == OP_PAUSE) begin
                            n_running[s_idx] = 1'b0;
                            n_cnt = r_cnt - 5'(s_counted);
                        end else if (!r_cancel[s_idx]) begin
                            // Resume is refused silently on a cancelled slot.
                            n_running[s_idx] = 1'b1;
                            n_cnt = r_cnt + 5'(!r_running[s_idx]);
                        end
                    end
                    OP_COUNT: begin
                        n_rslot = 4'd0;
                    end
                    OP_QUERY: begin
                        n_exists = s_ok;
                    end
                    default: begin
                        n_rslot = 4'd0;
                    end
                endcase
            end

            // Pipelined sweep: read at r_idx, add one slot behind, compare two behind.
            ST_TICK: begin
                n_a_vld = (r_idx < CNT_W'(SLOT_COUNT));
                if (r_b_vld && r_b_act) begin
                    el_we = 1'b1;
                    if (b_ge) begin
                        if (r_fire_n < 5'(MAX_OUT)) begin
                            n_fired[r_b_idx] = 1'b1;
                            n_fire_n         = r_fire_n + 5'd1;
                        end
                        if (r_b_per) begin
                            el_wdata              = b_diff_w[TIME_BITS-1:0];
                            n_has_fired[r_b_idx]  = 1'b1;
                            n_cnt                 = r_cnt + 5'd1;
                        end else begin
                            n_cancel[r_b_idx]  = 1'b1;
                            n_running[r_b_idx] = 1'b0;
                        end
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(SLOT_COUNT + 1)) begin
                    n_state = ST_FREE;
                end
            end

            // Free every cancelled slot at the end of the tick.
            ST_FREE: begin
                n_in_use    = r_in_use & ~r_cancel;
                n_running   = r_running & ~r_cancel;
                n_has_fired = r_has_fired & ~r_cancel;
                n_scaled    = r_scaled & ~r_cancel;
                n_cancel    = '0;
                n_single    = (r_fire_n == 5'd0);
                n_kind      = EV_ACK;
                n_rslot     = 4'd0;
                n_idx       = '0;
                n_emit_n    = '0;
                n_state     = ST_EMIT;
            end

            // Show results: one item for a command or a quiet tick, else each fired slot.
            ST_EMIT: begin
                if (r_single) begin
                    o_res_strobe      = 1'b1;
                    o_res.last_result = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    o_res.event_kind  = EV_FIRED;
                    o_res.result_slot = 4'(scan_idx);
                    o_res.last_result = (r_emit_n == r_fire_n - 5'd1);
                    if (r_fired[scan_idx]) begin
                        o_res_strobe = 1'b1;
                        n_emit_n     = r_emit_n + 5'd1;
                        if (r_emit_n == r_fire_n - 5'd1) begin
                            n_state = ST_IDLE;
                        end
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and slot flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_in_use    <= '0;
            r_running   <= '0;
            r_cancel    <= '0;
            r_has_fired <= '0;
            r_scaled    <= '0;
            r_fired     <= '0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_in_use    <= n_in_use;
            r_running   <= n_running;
            r_cancel    <= n_cancel;
            r_has_fired <= n_has_fired;
            r_scaled    <= n_scaled;
            r_fired     <= n_fired;
            r_a_vld     <= n_a_vld;
            r_b_vld     <= n_b_vld;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cnt      <= n_cnt;
        r_fire_n   <= n_fire_n;
        r_emit_n   <= n_emit_n;
        r_found    <= n_found;
        r_free_idx <= n_free_idx;
        r_single   <= n_single;
        r_kind     <= n_kind;
        r_rslot    <= n_rslot;
        r_exists   <= n_exists;
        r_a_idx    <= n_a_idx;
        r_b_idx    <= n_b_idx;
        r_b_act    <= n_b_act;
        r_b_per    <= n_b_per;
        r_b_sum    <= n_b_sum;
        r_b_thr    <= n_b_thr;
    end

    // Time memories: one write port each, registered read at the sweep address.
    always_ff @(posedge i_clk) begin
        if (el_we) begin
            mem_elapsed[el_waddr] <= el_wdata;
        end
        if (cfg_we) begin
            mem_delay[cfg_waddr]    <= TIME_BITS'(r_cmd.first_delay);
            mem_interval[cfg_waddr] <= TIME_BITS'(r_cmd.repeat_interval);
        end
        r_el_q <= mem_elapsed[rd_addr];
        r_dl_q <= mem_delay[rd_addr];
        r_iv_q <= mem_interval[rd_addr];
    end

    // Checks on the sequencer and the slot flags.
    `ASSERT_IMPL(a_strobe_busy, o_res_strobe, busy, "result shown while idle")
    `ASSERT_NEXT(a_last_idle, o_res_strobe && o_res.last_result, !busy, "busy after last result")
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but block not busy")
    `ASSERT_IMPL(a_fire_cap, r_state == ST_EMIT, r_fire_n <= 5'(MAX_OUT), "too many fire events")
    `ASSERT_IMPL(a_flags_in_use, 1'b1, ((r_running | r_cancel | r_has_fired) & ~r_in_use) == '0, "flag set on free slot")

endmodule

### dv/timer_event_checker.sv
// Checker for the multi-slot delay and interval timer: predicts the events of each item and
// compares them with the strobed results. Depends on msdit_pkg for the item types and codes.
`timescale 1ns / 100ps

module timer_event_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  msdit_pkg::t_cmd i_cmd,
    input  logic            i_res_strobe,
    input  msdit_pkg::t_res i_res,
    output int              o_fail_count,
    output int              o_pending
);
    import msdit_pkg::*;

    localparam int NSLOT = SLOT_COUNT_DEF;

    // Shadow copy of the timer table.
    logic [NSLOT-1:0] slot_used;
    logic [NSLOT-1:0] slot_run;
    logic [NSLOT-1:0] slot_cancel;
    logic [NSLOT-1:0] slot_fired;
    logic [NSLOT-1:0] slot_scale;
    logic [31:0]      slot_elapsed_q  [NSLOT];
    logic [31:0]      slot_delay_q    [NSLOT];
    logic [31:0]      slot_interval_q [NSLOT];

    // Events still owed by the block, oldest first.
    t_res expected_events[$];
    int   mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Returns a slot to the free pool with all its flags cleared.
    function automatic void release_slot(int i);
        slot_used[i]      = 1'b0;
        slot_run[i]       = 1'b0;
        slot_cancel[i]    = 1'b0;
        slot_fired[i]     = 1'b0;
        slot_scale[i]     = 1'b0;
        slot_elapsed_q[i] = '0;
    endfunction

    // Applies one item to the shadow table and queues the events it should cause.
    function automatic void predict_timer_results(t_cmd c);
        t_res        evs[$];
        t_res        r;
        logic [32:0] sum;
        logic [31:0] step;
        logic [31:0] thr;
        logic [31:0] now_time;
        logic        ok;
        int          found;
        int          idx;
        idx   = c.slot;
        ok    = slot_used[idx];
        found = -1;
        r     = '0;
        case (c.opcode) inside
            OP_TICK: begin
                // Advance every running slot, firing in ascending order.
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_used[i] && slot_run[i] && !slot_cancel[i]) begin
                        step     = slot_scale[i] ? c.tick_scaled : c.tick_unscaled;
                        sum      = {1'b0, slot_elapsed_q[i]} + {1'b0, step};
                        now_time = sum[32] ? '1 : sum[31:0];
                        thr      = slot_fired[i] ? slot_interval_q[i] : slot_delay_q[i];
                        slot_elapsed_q[i] = now_time;
                        if (now_time >= thr) begin
                            if (evs.size() < MAX_OUT) begin
                                r.event_kind  = EV_FIRED;
                                r.result_slot = 4'(i);
                                evs = {evs, r};
                            end
                            if (slot_interval_q[i] != '0) begin
                                slot_elapsed_q[i] = now_time - thr;
                                slot_fired[i]     = 1'b1;
                            end else begin
                                slot_cancel[i] = 1'b1;
                                slot_run[i]    = 1'b0;
                            end
                        end
                    end
                end
                // Cancelled slots leave the table at the end of the tick.
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_used[i] && slot_cancel[i]) begin
                        release_slot(i);
                    end
                end
                if (evs.size() == 0) begin
                    r.event_kind  = EV_ACK;
                    r.result_slot = '0;
                    evs = {evs, r};
                end
            end
            OP_CREATE: begin
                for (int i = NSLOT - 1; i >= 0; i--) begin
                    if (!slot_used[i]) begin
                        found = i;
                    end
                end
                if (found < 0) begin
                    r.event_kind  = EV_FULL;
                    r.result_slot = '0;
                end else begin
                    release_slot(found);
                    slot_used[found]       = 1'b1;
                    slot_run[found]        = 1'b1;
                    slot_scale[found]      = c.use_scaled;
                    slot_delay_q[found]    = c.first_delay;
                    slot_interval_q[found] = c.repeat_interval;
                    r.event_kind  = EV_ACK;
                    r.result_slot = 4'(found);
                end
                evs = {evs, r};
            end
            OP_DESTROY, OP_CANCEL, OP_PAUSE, OP_RESUME: begin
                r.result_slot = c.slot;
                if (!ok) begin
                    r.event_kind = EV_NO_SLOT;
                end else begin
                    r.event_kind = EV_ACK;
                    case (c.opcode)
                        OP_DESTROY: begin
                            release_slot(idx);
                        end
                        OP_CANCEL: begin
                            slot_cancel[idx] = 1'b1;
                            slot_run[idx]    = 1'b0;
                        end
                        OP_PAUSE: begin
                            slot_run[idx] = 1'b0;
                        end
                        default: begin
                            // A cancelled slot cannot be restarted.
                            if (!slot_cancel[idx]) begin
                                slot_run[idx] = 1'b1;
                            end
                        end
                    endcase
                end
                evs = {evs, r};
            end
            OP_COUNT: begin
                r.event_kind  = EV_ACK;
                r.result_slot = '0;
                evs = {evs, r};
            end
            default: begin
                r.event_kind  = EV_ACK;
                r.result_slot = c.slot;
                r.slot_exists = ok;
                evs = {evs, r};
            end
        endcase
        // Every event of the item carries the count after the item is done.
        for (int k = 0; k < evs.size(); k++) begin
            r = evs[k];
            r.running_count = 5'($countones(slot_used & slot_run & ~slot_cancel));
            r.last_result   = (k == evs.size() - 1);
            expected_events = {expected_events, r};
        end
    endfunction

    // Compares one strobed event with the oldest one owed.
    task automatic compare_result(input t_res got);
        t_res want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event with none expected: kind %0d slot %0d",
                                      got.event_kind, got.result_slot));
        end else begin
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind) begin
                report_mismatch($sformatf("event_kind got %0d want %0d",
                                          got.event_kind, want.event_kind));
            end
            if (got.result_slot !== want.result_slot) begin
                report_mismatch($sformatf("result_slot got %0d want %0d",
                                          got.result_slot, want.result_slot));
            end
            if (got.running_count !== want.running_count) begin
                report_mismatch($sformatf("running_count got %0d want %0d",
                                          got.running_count, want.running_count));
            end
            if (got.slot_exists !== want.slot_exists) begin
                report_mismatch($sformatf("slot_exists got %0d want %0d",
                                          got.slot_exists, want.slot_exists));
            end
            if (got.last_result !== want.last_result) begin
                report_mismatch($sformatf("last_result got %0d want %0d",
                                          got.last_result, want.last_result));
            end
        end
    endtask

    // Results are checked before the item taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                release_slot(i);
                slot_delay_q[i]    = '0;
                slot_interval_q[i] = '0;
            end
            expected_events.delete();
        end else begin
            if (i_res_strobe) begin
                compare_result(i_res);
            end
            if (i_start && !i_busy) begin
                predict_timer_results(i_cmd);
            end
        end
        o_pending <= expected_events.size();
    end

endmodule

### dv/tb_multi_slot_delay_interval_timer.sv
// Testbench top for the multi-slot delay and interval timer: drives directed and random items.
// Depends on msdit_pkg, the timer RTL and timer_event_checker, which checks every result.
`timescale 1ns / 100ps

module tb_multi_slot_delay_interval_timer;
    import msdit_pkg::*;

    // A tick is the longest item and the sender may add a random gap, so quiet stretches
    // between items and events are normal; anything near this limit is a hang.
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 2 * SLOT_COUNT_DEF + 8;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_res_strobe;
    t_res o_res;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   max_gap;

    multi_slot_delay_interval_timer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    timer_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_res_strobe (o_res_strobe),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if no item and no event moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(t_op op, logic [3:0] slot, logic [31:0] dly,
                                      logic [31:0] ivl, logic sc, logic [31:0] ts,
                                      logic [31:0] tu);
        t_cmd c;
        c.opcode          = op;
        c.slot            = slot;
        c.first_delay     = dly;
        c.repeat_interval = ivl;
        c.use_scaled      = sc;
        c.tick_scaled     = ts;
        c.tick_unscaled   = tu;
        return c;
    endfunction

    // Delays and intervals: mostly a few time units, sometimes zero, full range or near max.
    function automatic logic [31:0] rand_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(1, 32'h0006_0000);
        endcase
    endfunction

    // Tick steps: mostly small so that slots fire now and then, not on every tick.
    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    // One random item; create_w is the percentage of creates, ticks take another 30.
    function automatic t_cmd make_random_cmd(int create_w);
        t_cmd c;
        int   r;
        r = $urandom_range(0, 99);
        if (r < create_w) begin
            c.opcode = OP_CREATE;
        end else if (r < create_w + 30) begin
            c.opcode = OP_TICK;
        end else begin
            c.opcode = t_op'(3'($urandom_range(OP_DESTROY, OP_QUERY)));
        end
        // Low slots are the ones most often in use.
        c.slot            = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(0, 7));
        c.first_delay     = rand_duration();
        c.repeat_interval = ($urandom_range(0, 3) == 0) ? '0 : rand_duration();
        c.use_scaled      = 1'($urandom_range(0, 1));
        c.tick_scaled     = rand_step();
        c.tick_unscaled   = rand_step();
        return c;
    endfunction

    // Presents one item after a random gap and returns at the edge that takes it.
    task automatic issue_cmd(input t_cmd c);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Holds the sender off until every owed event has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int create_w;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        max_gap = 6;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: missing slots, count and a quiet tick.
        issue_cmd(make_cmd(OP_QUERY,   4'd15, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_DESTROY, 4'd0,  '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_CANCEL,  4'd3,  '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_PAUSE,   4'd7,  '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_RESUME,  4'd9,  '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_COUNT,   4'd5,  '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_TICK,    4'd0,  '0, '0, 1'b0, '0, '0));

        // Zero one-shot, maximum periodic, a short periodic and a pending one-shot.
        issue_cmd(make_cmd(OP_CREATE, 4'd0, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_CREATE, 4'd0, '1, '1, 1'b1, '0, '0));
        issue_cmd(make_cmd(OP_CREATE, 4'd0, 32'h0001_0000, 32'h0000_8000, 1'b1, '0, '0));
        issue_cmd(make_cmd(OP_CREATE, 4'd0, 32'h0002_0000, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_QUERY,  4'd0, '0, '0, 1'b0, '0, '0));

        // Saturating ticks: several fires in one tick, the one-shots are freed.
        issue_cmd(make_cmd(OP_TICK, 4'd0, '0, '0, 1'b0, '1, 32'h0000_FFFF));
        issue_cmd(make_cmd(OP_TICK, 4'd0, '0, '0, 1'b0, '1, '1));

        // Pause and resume, then resume after cancel and destroy of a cancelled slot.
        issue_cmd(make_cmd(OP_PAUSE,   4'd2, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_TICK,    4'd0, '0, '0, 1'b0, 32'h0000_8000, 32'h0000_8000));
        issue_cmd(make_cmd(OP_RESUME,  4'd2, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_CANCEL,  4'd1, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_RESUME,  4'd1, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_QUERY,   4'd1, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_DESTROY, 4'd1, '0, '0, 1'b0, '0, '0));

        // A cancelled slot lives until the end of the next tick.
        issue_cmd(make_cmd(OP_CANCEL, 4'd2, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_TICK,   4'd0, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_QUERY,  4'd2, '0, '0, 1'b0, '0, '0));
        issue_cmd(make_cmd(OP_COUNT,  4'd0, '0, '0, 1'b0, '0, '0));
        wait_for_results();

        // Fill the table past full, then fire every slot in one tick.
        for (int n = 0; n < SLOT_COUNT_DEF + 1; n++) begin
            issue_cmd(make_cmd(OP_CREATE, 4'($urandom), rand_duration(),
                               ($urandom_range(0, 2) == 0) ? '0 : rand_duration(),
                               1'($urandom_range(0, 1)), '0, '0));
        end
        issue_cmd(make_cmd(OP_TICK, 4'd0, '0, '0, 1'b0, '1, '1));
        wait_for_results();

        // Random phases, alternating busy and sparse tables, some with back-to-back items.
        for (int phase = 0; phase < 4; phase++) begin
            max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 6;
            create_w = (phase % 2 == 0) ? 40 : 12;
            for (int n = 0; n < 70; n++) begin
                issue_cmd(make_random_cmd(create_w));
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/msdit_pkg.sv
design/multi_slot_delay_interval_timer.sv
dv/timer_event_checker.sv
dv/tb_multi_slot_delay_interval_timer.sv
